// ===== sv/reliable_send_window_core_macros.svh =====
// assertion macros for the reliable send window core
`ifndef RELIABLE_SEND_WINDOW_CORE_MACROS_SVH
`define RELIABLE_SEND_WINDOW_CORE_MACROS_SVH

`define RSW_ASSERT_IMP(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error(msg);

`define RSW_ASSERT_NXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error(msg);

`endif

// ===== sv/rsw_pkg.sv =====
// package for the reliable send window core: types and constants
`default_nettype none
package rsw_pkg;

   localparam int PendingDepthDef = 64;
   localparam int WindowMaxDef    = 32;
   localparam int SendCap         = 32;
   localparam int SeqW            = 63;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_CLOSE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      RES_SEND   = 2'd0,
      RES_REQACK = 2'd1,
      RES_STATUS = 2'd2
   } res_kind_type;

   typedef enum logic [1:0] {
      CSR_RETRY    = 2'd0,
      CSR_STARTWIN = 2'd1,
      CSR_MAXWIN   = 2'd2,
      CSR_STARTSEQ = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_ACK,
      ST_SCAN,
      ST_REQ,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [SeqW-1:0] op_seq;
      logic            has_completed;
      logic [SeqW-1:0] completed_seq;
      logic [SeqW-1:0] ack_received_seq;
      logic [SeqW-1:0] ack_quorum_seq;
   } req_type;

   typedef struct packed {
      logic [1:0]      result_kind;
      logic [SeqW-1:0] send_seq;
      logic [SeqW-1:0] completed_out;
      logic            progress;
      logic            overflow;
      logic [SeqW-1:0] not_received_count;
      logic [5:0]      window_size;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [SeqW-1:0] seq;
      logic [31:0]     stamp;
      logic            sent;
   } entry_type;

   // per-cycle command from the controller to the cell row
   typedef struct packed {
      logic            ins;
      logic [SeqW-1:0] ins_seq;
      logic [31:0]     ins_stamp;
      logic            ins_sent;
      logic            del;
      logic [SeqW-1:0] del_seq;
      logic            clear;
      logic            mark;
      logic [31:0]     now;
   } row_cmd_type;

endpackage
`default_nettype wire

// ===== sv/reliable_send_window_core.sv =====
// top level of the reliable send window core
//  channel | direction | handshake
//  req     | in        | start and not busy
//  rsp     | out       | rsp_strobe, one cycle, no back-pressure
//  csr     | in        | csr_valid and csr_ready
// an add passes through ST_ADD, which gives its send, then status; an ack
// removes head entries one at a time in ST_ACK, then scans; a scan reads the
// slots one at a time through the single read port of the cell row and pauses
// the reads for each send; an ack request adds a pass through ST_REQ.
// each result takes one cycle; status always comes last.
// synchronous reset clears the table valid bits and loads start values.
`default_nettype none
`include "reliable_send_window_core_macros.svh"
module reliable_send_window_core
   import rsw_pkg::*;
#(
   parameter int PENDING_DEPTH = PendingDepthDef,
   parameter int WINDOW_MAX    = WindowMaxDef
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [62:0] csr_wdata
);
   localparam int IW = $clog2(PENDING_DEPTH);
   localparam int CW = $clog2(PENDING_DEPTH + 1);
   localparam int WW = 6;
   localparam logic [15:0]     RetryReset    = 16'd100;
   localparam logic [WW-1:0]   StartWinReset = 6'd4;
   localparam logic [WW-1:0]   MaxWinReset   = 6'd32;
   localparam logic [SeqW-1:0] StartSeqReset = '0;

   logic [15:0]     retry_ff;
   logic [WW-1:0]   mwin_ff;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic [SeqW-1:0] lrcv_ff, lrcv_in, lapp_ff, lapp_in, high_ff, high_in, comp_ff, comp_in;
   logic [WW-1:0]   win_ff, win_in;
   logic            noack_ff, noack_in, ton_ff, ton_in, act_ff, act_in;
   logic [15:0]     tleft_ff, tleft_in;
   logic [31:0]     now_ff, now_in;
   logic            prog_ff, prog_in, ovf_ff, ovf_in, req_ff2, req_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   scnt_ff, scnt_in;
   logic [SeqW-1:0] sendq_ff, sendq_in;
   logic            sendv_ff, sendv_in;

   row_cmd_type cmd;
   logic        dup, head_del, sel_valid;
   entry_type   sel_entry;

   rsw_row #(.PENDING_DEPTH(PENDING_DEPTH)) u_row (
      .clock(clock), .reset(reset), .cmd(cmd), .sel(idx_ff[IW-1:0]),
      .dup(dup), .head_del(head_del), .sel_entry(sel_entry), .sel_valid(sel_valid)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !reset && (state_ff == ST_IDLE) && !start;

   function automatic logic [WW-1:0] clampw(input logic [WW-1:0] x);
      logic [WW-1:0] r;
      r = x;
      if (x == '0) r = WW'(1);
      if (x > WW'(WINDOW_MAX)) r = WW'(WINDOW_MAX);
      return r;
   endfunction

   logic [31:0] age;
   logic        stale, scan_done, cap_hit;
   logic [WW-1:0] mx;
   logic [WW:0]   dbl;
   assign age   = now_ff - sel_entry.stamp;
   assign stale = !sel_entry.sent || ({16'd0, age} >= {32'd0, retry_ff});
   assign cap_hit = (scnt_ff >= CW'(win_ff)) || (scnt_ff >= CW'(SendCap));
   assign scan_done = (idx_ff >= count_ff) || !sel_valid || (stale && cap_hit);
   assign mx  = (mwin_ff == '0) ? WW'(WINDOW_MAX) : clampw(mwin_ff);
   assign dbl = {win_ff, 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_STATUS;
               if (act_ff) begin
                  case (kind_type'(req_data.kind))
                     KIND_ADD:  state_in = ST_ADD;
                     KIND_ACK:  state_in = ST_ACK;
                     KIND_TICK:
                        if (ton_ff && tleft_ff <= 16'd1) state_in = ST_SCAN;
                     default:   state_in = ST_STATUS;
                  endcase
               end
            end
         end
         ST_ADD:    state_in = ST_STATUS;
         ST_ACK:    if (!(head_del && req_ff.ack_received_seq > lrcv_ff)) state_in = ST_SCAN;
         ST_SCAN:   if (scan_done && !sendv_ff) begin
                       state_in = (req_ff2 && count_ff == '0 && lapp_ff < lrcv_ff) ?
                          ST_REQ : ST_STATUS;
                    end
         ST_REQ:    state_in = ST_STATUS;
         ST_STATUS: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff; lrcv_in = lrcv_ff; lapp_in = lapp_ff; high_in = high_ff;
      comp_in = comp_ff; win_in = win_ff; noack_in = noack_ff; ton_in = ton_ff;
      act_in = act_ff; tleft_in = tleft_ff; now_in = now_ff; prog_in = prog_ff;
      ovf_in = ovf_ff; req_in = req_ff2; idx_in = idx_ff; scnt_in = scnt_ff;
      sendq_in = sendq_ff; sendv_in = 1'b0;
      cmd = '0;
      cmd.now = now_ff;
      cmd.ins_seq = req_ff.op_seq;
      cmd.ins_stamp = now_ff;
      cmd.del_seq = req_ff.ack_received_seq;
      rsp_strobe = 1'b0;
      rsp_data = '0;
      rsp_data.completed_out = comp_ff;
      case (state_ff)
         ST_IDLE: begin
            prog_in = 1'b0; ovf_in = 1'b0; req_in = 1'b0; idx_in = '0; scnt_in = '0;
            if (start) begin
               case (kind_type'(req_data.kind))
                  KIND_TICK: begin
                     now_in = now_ff + 32'd1;
                     if (act_ff && ton_ff) begin
                        if (tleft_ff <= 16'd1) begin
                           if (noack_ff && win_ff > WW'(1)) win_in = win_ff >> 1;
                           noack_in = 1'b1;
                           // scan prologue lives in ST_SCAN with idx zero
                           req_in = 1'b1;
                        end else begin
                           tleft_in = tleft_ff - 16'd1;
                        end
                     end
                  end
                  KIND_CLOSE: if (act_ff) begin
                     count_in = '0; act_in = 1'b0; ton_in = 1'b0;
                     cmd.clear = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            if (req_ff.has_completed) comp_in = req_ff.completed_seq;
            rsp_data.completed_out = comp_in;
            if (!dup && req_ff.op_seq > lrcv_ff) begin
               if (count_ff >= CW'(PENDING_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  cmd.ins = 1'b1;
                  cmd.ins_sent = (count_ff < CW'(win_ff));
                  if (!cmd.ins_sent) cmd.ins_stamp = '0;
                  count_in = count_ff + CW'(1);
                  if (req_ff.op_seq > high_ff) high_in = req_ff.op_seq;
                  if (!ton_ff) begin
                     ton_in = 1'b1; tleft_in = retry_ff;
                  end
                  if (cmd.ins_sent) begin
                     rsp_strobe = 1'b1;
                     rsp_data.result_kind = RES_SEND;
                     rsp_data.send_seq = req_ff.op_seq;
                  end
               end
            end
         end
         ST_ACK: begin
            if (req_ff.ack_received_seq > lrcv_ff && head_del) begin
               cmd.del = 1'b1;
               count_in = count_ff - CW'(1);
            end else begin
               req_in = 1'b0;
               if (req_ff.ack_received_seq > lrcv_ff) begin
                  lrcv_in = req_ff.ack_received_seq; prog_in = 1'b1;
               end
               if (req_ff.ack_quorum_seq > lapp_ff) begin
                  lapp_in = req_ff.ack_quorum_seq; prog_in = 1'b1;
               end
               if (req_ff.ack_received_seq > lrcv_ff || req_ff.ack_quorum_seq > lapp_ff) begin
                  noack_in = 1'b0;
                  if (win_ff < mx) win_in = clampw(dbl[WW] ? WW'(WINDOW_MAX) : dbl[WW-1:0]);
               end
            end
            // hold deletion's received point until the row is drained
            if (cmd.del) lrcv_in = lrcv_ff;
         end
         ST_SCAN: begin
            if (sendv_ff) begin
               rsp_strobe = 1'b1;
               rsp_data.result_kind = RES_SEND;
               rsp_data.send_seq = sendq_ff;
            end
            if (count_ff == '0) begin
               if (!(lapp_ff >= lrcv_ff)) begin
                  ton_in = 1'b1; tleft_in = retry_ff;
               end else begin
                  ton_in = 1'b0; req_in = 1'b0;
               end
            end else begin
               req_in = 1'b0;
               if (!scan_done && !sendv_ff) begin
                  if (stale) begin
                     cmd.mark = 1'b1;
                     sendq_in = sel_entry.seq;
                     sendv_in = 1'b1;
                     scnt_in = scnt_ff + CW'(1);
                  end
                  idx_in = idx_ff + CW'(1);
               end
               if (scan_done && !sendv_ff) begin
                  ton_in = 1'b1; tleft_in = retry_ff;
               end
            end
         end
         ST_REQ: begin
            rsp_strobe = 1'b1;
            rsp_data.result_kind = RES_REQACK;
         end
         ST_STATUS: begin
            rsp_strobe = 1'b1;
            rsp_data.result_kind = RES_STATUS;
            rsp_data.progress = prog_ff;
            rsp_data.overflow = ovf_ff;
            rsp_data.not_received_count = (high_ff > lrcv_ff) ? high_ff - lrcv_ff : '0;
            rsp_data.window_size = win_ff;
            rsp_data.last = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         lrcv_ff <= StartSeqReset; lapp_ff <= StartSeqReset; high_ff <= StartSeqReset;
         comp_ff <= '0;
         win_ff <= clampw(StartWinReset);
         noack_ff <= 1'b0; ton_ff <= 1'b0; act_ff <= 1'b1;
         tleft_ff <= '0; now_ff <= '0;
         prog_ff <= 1'b0; ovf_ff <= 1'b0; req_ff2 <= 1'b0;
         idx_ff <= '0; scnt_ff <= '0; sendv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         lrcv_ff <= lrcv_in; lapp_ff <= lapp_in; high_ff <= high_in;
         comp_ff <= comp_in; win_ff <= win_in;
         noack_ff <= noack_in; ton_ff <= ton_in; act_ff <= act_in;
         tleft_ff <= tleft_in; now_ff <= now_in;
         prog_ff <= prog_in; ovf_ff <= ovf_in; req_ff2 <= req_in;
         idx_ff <= idx_in; scnt_ff <= scnt_in; sendv_ff <= sendv_in;
      end
      sendq_ff <= sendq_in;
      if (start && !busy) req_ff <= req_data;
   end

   // start window and start sequence writes are ignored; reset loads fixed defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= RetryReset;
         mwin_ff  <= MaxWinReset;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_RETRY:  retry_ff <= csr_wdata[15:0];
            CSR_MAXWIN: mwin_ff  <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   logic unused_csr;
   assign unused_csr = ^csr_wdata[62:16];

   `RSW_ASSERT_IMP(a_status_last, clock, reset,
      rsp_strobe && rsp_data.last, state_ff == ST_STATUS, "last flag outside status")
   `RSW_ASSERT_IMP(a_count_max, clock, reset,
      1'b1, count_ff <= CW'(PENDING_DEPTH), "pending count above depth")
   `RSW_ASSERT_NXT(a_status_idle, clock, reset,
      state_ff == ST_STATUS, !busy, "not idle after status")
endmodule
`default_nettype wire

// ===== sv/rsw_cell.sv =====
// one table slot of the sorted pending row
`default_nettype none
module rsw_cell
   import rsw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire row_cmd_type cmd,
   input  wire logic        prev_valid,
   input  wire logic        prev_gt,
   input  wire entry_type   prev_entry,
   input  wire logic        next_valid,
   input  wire logic        next_del,
   input  wire entry_type   next_entry,
   input  wire logic        mark_me,
   output logic             valid,
   output logic             gt,
   output logic             del_me,
   output entry_type        entry
);
   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;

   assign valid  = valid_ff;
   assign entry  = entry_ff;
   assign gt     = valid_ff && (entry_ff.seq > cmd.ins_seq);
   assign del_me = valid_ff && (entry_ff.seq <= cmd.del_seq);

   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.clear) begin
         valid_in = 1'b0;
      end else if (cmd.ins) begin
         if (prev_gt) begin
            // shift towards the tail, the first free slot takes the old tail
            valid_in = 1'b1;
            entry_in = prev_entry;
         end else if (gt || (!valid_ff && prev_valid)) begin
            valid_in = 1'b1;
            entry_in.seq   = cmd.ins_seq;
            entry_in.stamp = cmd.ins_stamp;
            entry_in.sent  = cmd.ins_sent;
         end
      end else if (cmd.del) begin
         // head removal, one slot per cycle
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (cmd.mark && mark_me) begin
         entry_in.sent  = 1'b1;
         entry_in.stamp = cmd.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      entry_ff <= entry_in;
   end

   logic unused_nd;
   assign unused_nd = next_del;
endmodule
`default_nettype wire

// ===== sv/rsw_row.sv =====
// row of cells holding the sorted pending table
`default_nettype none
module rsw_row
   import rsw_pkg::*;
#(
   parameter int PENDING_DEPTH = PendingDepthDef
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire row_cmd_type                       cmd,
   input  wire logic [$clog2(PENDING_DEPTH)-1:0]  sel,
   output logic                                   dup,
   output logic                                   head_del,
   output entry_type                              sel_entry,
   output logic                                   sel_valid
);
   localparam int IW = $clog2(PENDING_DEPTH);
   logic      v   [PENDING_DEPTH];
   logic      g   [PENDING_DEPTH];
   logic      d   [PENDING_DEPTH];
   entry_type e   [PENDING_DEPTH];
   logic [PENDING_DEPTH-1:0] eq;

   for (genvar i = 0; i < PENDING_DEPTH; i++) begin : g_cell
      logic      pv, pg, nv, nd;
      entry_type pe, ne;
      if (i == 0) begin : g_first
         assign pv = 1'b1;
         assign pg = 1'b0;
         assign pe = '0;
      end else begin : g_mid
         assign pv = v[i-1];
         assign pg = g[i-1];
         assign pe = e[i-1];
      end
      if (i == PENDING_DEPTH-1) begin : g_last
         assign nv = 1'b0;
         assign nd = 1'b0;
         assign ne = '0;
      end else begin : g_nx
         assign nv = v[i+1];
         assign nd = d[i+1];
         assign ne = e[i+1];
      end
      assign eq[i] = v[i] && (e[i].seq == cmd.ins_seq);
      rsw_cell u_cell (
         .clock(clock), .reset(reset), .cmd(cmd),
         .prev_valid(pv), .prev_gt(pg), .prev_entry(pe),
         .next_valid(nv), .next_del(nd), .next_entry(ne),
         .mark_me(sel == IW'(i)),
         .valid(v[i]), .gt(g[i]), .del_me(d[i]), .entry(e[i])
      );
   end

   assign dup       = |eq;
   assign head_del  = d[0];
   assign sel_entry = e[sel];
   assign sel_valid = v[sel];
endmodule
`default_nettype wire

// ===== tb/sv/rsw_scoreboard.sv =====
// checker for the reliable send window core: watches all channels, predicts and compares
`timescale 1ns / 1ps
module rsw_scoreboard
   import rsw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire req_type     req_data,
   input  wire logic        rsp_strobe,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [62:0] csr_wdata,
   output int               results_owed,
   output int               fail_count
);

   logic [62:0] tbl_seq [64];
   logic [31:0] tbl_stamp [64];
   bit          tbl_sent [64];
   int unsigned tbl_n;
   logic [62:0] rcv_point, app_point, top_added, done_seq;
   int unsigned win;
   bit          no_ack, tmr_on, live;
   logic [15:0] tmr_left;
   logic [31:0] ticks;
   logic [15:0] cfg_retry;
   logic [5:0]  cfg_swin, cfg_mwin;
   logic [62:0] cfg_sseq;
   rsp_type     owed_results [$];

   function automatic int unsigned clamp_win(int unsigned v);
      if (v < 1) return 1;
      if (v > WindowMaxDef) return WindowMaxDef;
      return v;
   endfunction

   task automatic report(string what, logic [62:0] got, logic [62:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic owe(res_kind_type k, logic [62:0] seq);
      rsp_type e;
      e = '0;
      e.result_kind = k;
      e.send_seq = seq;
      e.completed_out = done_seq;
      owed_results.insert(owed_results.size(), e);
   endtask

   task automatic arm_timer();
      tmr_on = 1;
      tmr_left = cfg_retry;
   endtask

   task automatic resend_scan(output bit want_req);
      int unsigned i, sent;
      logic [31:0] age;
      sent = 0;
      want_req = 0;
      if (tbl_n == 0) begin
         if (app_point >= rcv_point) begin
            tmr_on = 0;
            return;
         end
         want_req = 1;
      end else begin
         for (i = 0; i < tbl_n; i++) begin
            age = ticks - tbl_stamp[i];
            if (!tbl_sent[i] || age >= {16'd0, cfg_retry}) begin
               if (sent >= win || sent >= SendCap) break;
               tbl_sent[i] = 1;
               tbl_stamp[i] = ticks;
               owe(RES_SEND, tbl_seq[i]);
               sent++;
            end
         end
      end
      arm_timer();
   endtask

   task automatic do_add(req_type r, inout bit ovf);
      int unsigned pos, j;
      bit go;
      if (r.has_completed) done_seq = r.completed_seq;
      for (pos = 0; pos < tbl_n; pos++) begin
         if (tbl_seq[pos] == r.op_seq) return;
         if (tbl_seq[pos] > r.op_seq) break;
      end
      if (r.op_seq <= rcv_point) return;
      if (tbl_n >= PendingDepthDef) begin
         ovf = 1;
         return;
      end
      go = tbl_n < win;
      for (j = tbl_n; j > pos; j--) begin
         tbl_seq[j] = tbl_seq[j-1];
         tbl_stamp[j] = tbl_stamp[j-1];
         tbl_sent[j] = tbl_sent[j-1];
      end
      tbl_seq[pos] = r.op_seq;
      tbl_stamp[pos] = go ? ticks : 32'd0;
      tbl_sent[pos] = go;
      tbl_n++;
      if (r.op_seq > top_added) top_added = r.op_seq;
      if (!tmr_on) arm_timer();
      if (go) owe(RES_SEND, r.op_seq);
   endtask

   task automatic do_ack(req_type r, inout bit prog);
      int unsigned k, j, mx;
      bit dummy;
      if (r.ack_received_seq > rcv_point) begin
         k = 0;
         while (k < tbl_n && tbl_seq[k] <= r.ack_received_seq) k++;
         for (j = k; j < tbl_n; j++) begin
            tbl_seq[j-k] = tbl_seq[j];
            tbl_stamp[j-k] = tbl_stamp[j];
            tbl_sent[j-k] = tbl_sent[j];
         end
         tbl_n -= k;
         rcv_point = r.ack_received_seq;
         prog = 1;
      end
      if (r.ack_quorum_seq > app_point) begin
         app_point = r.ack_quorum_seq;
         prog = 1;
      end
      if (prog) begin
         mx = (cfg_mwin == 0) ? WindowMaxDef : clamp_win(cfg_mwin);
         no_ack = 0;
         if (win < mx) win = clamp_win(win * 2);
      end
      resend_scan(dummy);
   endtask

   task automatic predict_item(req_type r);
      bit prog, ovf, want_req;
      rsp_type st;
      prog = 0;
      ovf = 0;
      case (kind_type'(r.kind))
         KIND_ADD: if (live) do_add(r, ovf);
         KIND_ACK: if (live) do_ack(r, prog);
         KIND_TICK: begin
            ticks++;
            if (live && tmr_on) begin
               if (tmr_left <= 1) begin
                  if (no_ack && win > 1) win = win / 2;
                  no_ack = 1;
                  resend_scan(want_req);
                  if (want_req) owe(RES_REQACK, '0);
               end else tmr_left--;
            end
         end
         default: if (live) begin
            tbl_n = 0;
            live = 0;
            tmr_on = 0;
         end
      endcase
      st = '0;
      st.result_kind = RES_STATUS;
      st.completed_out = done_seq;
      st.progress = prog;
      st.overflow = ovf;
      st.not_received_count = (top_added > rcv_point) ? top_added - rcv_point : '0;
      st.window_size = win[5:0];
      st.last = 1;
      owed_results.insert(owed_results.size(), st);
   endtask

   task automatic compare_result(rsp_type got);
      rsp_type want;
      if (owed_results.size() == 0) begin
         report("unexpected result", got.send_seq, '0);
         return;
      end
      want = owed_results.pop_front();
      if (got.result_kind !== want.result_kind)
         report("result_kind", got.result_kind, want.result_kind);
      if (got.send_seq !== want.send_seq) report("send_seq", got.send_seq, want.send_seq);
      if (got.completed_out !== want.completed_out)
         report("completed_out", got.completed_out, want.completed_out);
      if (got.progress !== want.progress) report("progress", got.progress, want.progress);
      if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
      if (got.not_received_count !== want.not_received_count)
         report("not_received_count", got.not_received_count, want.not_received_count);
      if (got.window_size !== want.window_size)
         report("window_size", got.window_size, want.window_size);
      if (got.last !== want.last) report("last", got.last, want.last);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         cfg_retry = 16'd100;
         cfg_swin = 6'd4;
         cfg_mwin = 6'd32;
         cfg_sseq = '0;
         tbl_n = 0;
         rcv_point = cfg_sseq;
         app_point = cfg_sseq;
         top_added = cfg_sseq;
         win = clamp_win(cfg_swin);
         no_ack = 0;
         tmr_on = 0;
         tmr_left = '0;
         ticks = '0;
         done_seq = '0;
         live = 1;
         owed_results.delete();
      end else begin
         if (rsp_strobe) compare_result(rsp_data);
         if (start && !busy) predict_item(req_data);
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RETRY:    cfg_retry = csr_wdata[15:0];
               CSR_STARTWIN: cfg_swin = csr_wdata[5:0];
               CSR_MAXWIN:   cfg_mwin = csr_wdata[5:0];
               default:      cfg_sseq = csr_wdata;
            endcase
         end
      end
      results_owed = owed_results.size();
   end

endmodule

// ===== tb/sv/tb_reliable_send_window_core.sv =====
// testbench top for the reliable send window core: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_reliable_send_window_core;
   import rsw_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [62:0] csr_wdata = '0;
   int          results_owed, fail_count;
   int          quiet_cycles = 0;
   bit          no_gaps = 0;
   longint      next_seq = 1, acked = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   reliable_send_window_core dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   rsw_scoreboard checker_inst (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata, .results_owed, .fail_count
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_reliable_send_window_core: done, errors");
         $finish;
      end
   end

   function automatic logic [62:0] rand63();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type noise_item();
      req_type r;
      r.kind = 2'($urandom_range(0, 2));
      r.op_seq = rand63();
      r.has_completed = $urandom_range(0, 1);
      r.completed_seq = rand63();
      r.ack_received_seq = rand63();
      r.ack_quorum_seq = rand63();
      return r;
   endfunction

   function automatic req_type mk_add(longint s, bit hc);
      req_type r;
      r = noise_item();
      r.kind = KIND_ADD;
      r.op_seq = s;
      r.has_completed = hc;
      return r;
   endfunction

   function automatic req_type mk_ack(longint rcv, longint quo);
      req_type r;
      r = noise_item();
      r.kind = KIND_ACK;
      r.ack_received_seq = rcv;
      r.ack_quorum_seq = quo;
      return r;
   endfunction

   function automatic req_type mk_kind(kind_type k);
      req_type r;
      r = noise_item();
      r.kind = k;
      return r;
   endfunction

   task automatic send_item(req_type r);
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic maybe_gap();
      if (!no_gaps && $urandom_range(0, 99) < 30)
         repeat ($urandom_range(1, 4)) begin
            start <= 0;
            @(posedge clock);
         end
   endtask

   task automatic drain();
      start <= 0;
      do @(posedge clock); while (results_owed != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [62:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_timing(int retry, int maxw);
      write_reg(CSR_RETRY, retry);
      write_reg(CSR_MAXWIN, maxw);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic well_formed_item();
      int p;
      longint s, rcv, quo;
      p = $urandom_range(0, 99);
      if (p < 45) begin
         if ($urandom_range(0, 9) == 0) s = next_seq - $urandom_range(1, 6);
         else s = next_seq + $urandom_range(0, 3);
         if (s < 0) s = 0;
         if (s >= next_seq) next_seq = s + 1;
         send_item(mk_add(s, $urandom_range(0, 1)));
      end else if (p < 65) begin
         if ($urandom_range(0, 9) == 0) rcv = acked - $urandom_range(0, 3);
         else rcv = acked + $urandom_range(0, int'(next_seq - acked));
         if (rcv < 0) rcv = 0;
         if (rcv > acked) acked = rcv;
         quo = rcv - longint'($urandom_range(0, 4));
         if (quo < 0) quo = 0;
         send_item(mk_ack(rcv, quo));
      end else if (p < 95) send_item(mk_kind(KIND_TICK));
      else begin
         req_type r;
         r = noise_item();
         r.op_seq = next_seq + $urandom_range(0, 40);
         r.ack_received_seq = acked + $urandom_range(0, 2);
         r.ack_quorum_seq = acked;
         if (r.kind == KIND_ADD && r.op_seq >= next_seq) next_seq = r.op_seq + 1;
         if (r.kind == KIND_ACK && r.ack_received_seq > acked) acked = r.ack_received_seq;
         send_item(r);
      end
      maybe_gap();
   endtask

   task automatic random_phase(int retry, int maxw, int count);
      drain();
      set_timing(retry, maxw);
      for (int i = 0; i < count; i++) begin
         no_gaps = (i >= count / 3 && i < count / 3 + 40);
         well_formed_item();
      end
      no_gaps = 0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(CSR_STARTWIN, 6'd1);
      write_reg(CSR_STARTSEQ, 63'h7FFF_FFFF_FFFF_FFFF);
      write_reg(CSR_RETRY, 16'd2);
      write_reg(CSR_MAXWIN, 6'd32);
      csr_valid <= 0;
      @(posedge clock);

      // directed: sends, holds, duplicates, stale adds, timer, acks out of order
      for (int s = 1; s <= 6; s++) send_item(mk_add(s, s[0]));
      send_item(mk_add(3, 1));
      send_item(mk_add(0, 0));
      repeat (4) send_item(mk_kind(KIND_TICK));
      send_item(mk_ack(2, 1));
      send_item(mk_ack(1, 5));
      repeat (3) send_item(mk_kind(KIND_TICK));
      send_item(mk_ack(6, 6));
      repeat (3) send_item(mk_kind(KIND_TICK));
      send_item(mk_add(7, 0));
      send_item(mk_ack(7, 6));
      repeat (3) send_item(mk_kind(KIND_TICK));
      next_seq = 8;
      acked = 7;

      random_phase(1, 1, 60);
      random_phase(3, 32, 60);
      random_phase(5, 8, 40);

      // table overflow with the timer held off
      drain();
      set_timing(65535, 32);
      for (int i = 0; i < 70; i++) begin
         send_item(mk_add(next_seq, 1));
         next_seq++;
      end
      send_item(mk_ack(next_seq - 1, next_seq - 1));
      acked = next_seq - 1;

      random_phase(2, 16, 60);

      // full-width fields, then close and inactive behaviour
      drain();
      write_reg(CSR_STARTWIN, 6'd32);
      write_reg(CSR_STARTSEQ, '0);
      set_timing(1, 32);
      for (int i = 0; i < 30; i++) begin
         send_item(noise_item());
         maybe_gap();
      end
      send_item(mk_add(63'h7FFF_FFFF_FFFF_FFFF, 1));
      send_item(mk_ack(63'h7FFF_FFFF_FFFF_FFFE, 63'h7FFF_FFFF_FFFF_FFFF));
      send_item(mk_kind(KIND_CLOSE));
      send_item(mk_kind(KIND_CLOSE));
      send_item(mk_add(63'h7FFF_FFFF_FFFF_FFFF, 1));
      send_item(mk_ack(63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF));
      repeat (3) send_item(mk_kind(KIND_TICK));
      drain();
      repeat (100) @(posedge clock);

      if (fail_count == 0 && results_owed == 0)
         $display("tb_reliable_send_window_core: done, clean");
      else
         $display("tb_reliable_send_window_core: done, errors");
      $finish;
   end

endmodule
